// ----- hw/rtl/vlsd_pkg.sv -----
// Package: shared types and constants for the prefix varint stream decoder.
`default_nettype none

package vlsd_pkg;

  // Header thresholds of the prefix varint format
  localparam logic [7:0] CutTwoByte = 8'd185;
  localparam logic [7:0] CutMulti   = 8'd249;

  // One decoded word as it leaves the decoder
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  length;
    logic        overlong;
    logic        block_end;
  } result_t;

  // Per-value decode state
  typedef struct packed {
    logic [2:0]  bytes_left;
    logic        two_byte_form;
    logic [31:0] accumulator;
    logic [2:0]  byte_position;
    logic [3:0]  length_so_far;
    logic        overlong_seen;
  } dec_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/varint_lite_stream_decoder_core.sv -----
// Top level: prefix varint byte stream decoder, one byte per clock when not stalled.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------------
//  input    | in_valid / in_ready   | byte_in[7:0]
//  output   | out_valid / out_ready | decoded_value, encoded_length, overlong, block_end
//  config   | cfg_we                | cfg_wdata[15:0] (values_per_block)
//
// One byte per clock unless stalled; a word goes via the input and output registers.
// A word appears only on the byte that ends a value (1 to 8 bytes per value).
// rst is synchronous and clears the decode state, block counter and register.
// A stall on out_ready holds the output word; the input register still takes
// one byte meanwhile, then in_ready drops until the word is taken.
`default_nettype none

module varint_lite_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      decoded_value,
  output logic [3:0]       encoded_length,
  output logic             overlong,
  output logic             block_end,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import vlsd_pkg::*;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        advance;
  logic        emit;
  result_t     result;
  result_t     out_word;
  logic [15:0] values_per_block;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      values_per_block <= 16'd0;
    end else if (cfg_we) begin
      values_per_block <= cfg_wdata;
    end
  end

  // decode a held byte whenever the output slot is free or draining
  assign advance = held_valid && (!out_valid || out_ready);

  vlsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  vlsd_decode u_decode (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .byte_val         (held_byte),
    .values_per_block (values_per_block),
    .emit             (emit),
    .result           (result)
  );

  vlsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .emit      (emit),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .held      (out_word)
  );

  assign decoded_value  = out_word.value;
  assign encoded_length = out_word.length;
  assign overlong       = out_word.overlong;
  assign block_end      = out_word.block_end;

endmodule

`default_nettype wire

// ----- hw/rtl/vlsd_in_reg.sv -----
// Input register: holds one accepted byte until the decoder consumes it.
`default_nettype none

module vlsd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_in,
  input  wire logic       advance,
  output logic            held_valid,
  output logic [7:0]      held_byte
);
  import vlsd_pkg::*;

  // free when empty or when the held byte is consumed this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= byte_in;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vlsd_decode.sv -----
// Decoder step: per-value state, block counter and the single-byte update logic.
`default_nettype none

module vlsd_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      byte_val,
  input  wire logic [15:0]     values_per_block,
  output logic                 emit,
  output vlsd_pkg::result_t    result
);
  import vlsd_pkg::*;

  dec_state_t  state;
  dec_state_t  state_next;
  logic [15:0] values_done;
  logic [15:0] values_done_next;
  logic [15:0] done_inc;
  logic        block_hit;
  logic [2:0]  left_dec;
  logic [31:0] acc_merged;

  assign left_dec = state.bytes_left - 3'd1;

  // merge the byte into its little-endian lane; lanes past the fourth are dropped
  always_comb begin
    acc_merged = state.accumulator;
    for (int i = 0; i < 4; i++) begin
      if (state.byte_position == 3'(i)) begin
        acc_merged[8*i +: 8] = state.accumulator[8*i +: 8] | byte_val;
      end
    end
  end

  // block count reached by the value completing now
  assign done_inc  = values_done + 16'd1;
  assign block_hit = (values_per_block != 16'd0)
                     && (done_inc >= values_per_block || done_inc == 16'd0);

  // next decode state and value completion
  always_comb begin
    state_next      = state;
    emit            = 1'b0;
    result.value    = 32'd0;
    result.length   = 4'd0;
    result.overlong = 1'b0;
    if (state.bytes_left == 3'd0) begin
      if (byte_val < CutTwoByte) begin
        emit          = 1'b1;
        result.value  = {24'd0, byte_val};
        result.length = 4'd1;
      end else begin
        state_next.length_so_far = 4'd1;
        state_next.byte_position = 3'd0;
        if (byte_val < CutMulti) begin
          state_next.two_byte_form = 1'b1;
          state_next.accumulator   = 32'(CutTwoByte) + {16'd0, byte_val - CutTwoByte, 8'd0};
          state_next.bytes_left    = 3'd1;
          state_next.overlong_seen = 1'b0;
        end else begin
          // headers 249..255 announce 1..7 bytes: header minus 248
          state_next.two_byte_form = 1'b0;
          state_next.accumulator   = 32'd0;
          state_next.bytes_left    = 3'(byte_val - (CutMulti - 8'd1));
          state_next.overlong_seen = (byte_val - (CutMulti - 8'd1)) > 8'd4;
        end
      end
    end else begin
      state_next.length_so_far = state.length_so_far + 4'd1;
      state_next.bytes_left    = left_dec;
      if (state.two_byte_form) begin
        emit                     = 1'b1;
        result.value             = state.accumulator + {24'd0, byte_val};
        result.length            = state.length_so_far + 4'd1;
        state_next.two_byte_form = 1'b0;
        state_next.bytes_left    = 3'd0;
        state_next.accumulator   = 32'd0;
      end else begin
        state_next.accumulator   = acc_merged;
        state_next.byte_position = state.byte_position + 3'd1;
        if (left_dec == 3'd0) begin
          emit                     = 1'b1;
          result.value             = acc_merged;
          result.length            = state.length_so_far + 4'd1;
          result.overlong          = state.overlong_seen;
          state_next.accumulator   = 32'd0;
          state_next.byte_position = 3'd0;
          state_next.overlong_seen = 1'b0;
        end
      end
    end
    result.block_end = emit && block_hit;
  end

  // block counter; a zero count disables it
  always_comb begin
    values_done_next = values_done;
    if (emit) begin
      if (values_per_block == 16'd0) begin
        values_done_next = 16'd0;
      end else if (block_hit) begin
        values_done_next = 16'd0;
      end else begin
        values_done_next = done_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      values_done <= 16'd0;
    end else if (step) begin
      state       <= state_next;
      values_done <= values_done_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vlsd_out_reg.sv -----
// Output register: holds one decoded word until the consumer takes it.
`default_nettype none

module vlsd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              emit,
  input  wire vlsd_pkg::result_t result,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output vlsd_pkg::result_t      held
);
  import vlsd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      held <= result;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vlsd_checker.sv -----
// Checker: port-level assertions for the decoder top level, with its bind.
`default_nettype none

module vlsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  byte_in,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] decoded_value,
  input wire logic [3:0]  encoded_length,
  input wire logic        overlong,
  input wire logic        block_end,
  input wire logic        cfg_we,
  input wire logic [15:0] cfg_wdata
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(decoded_value)
      && $stable(encoded_length) && $stable(overlong) && $stable(block_end))
    else $error("output word changed while stalled");

  // every word occupied one to eight bytes
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> encoded_length >= 4'd1 && encoded_length <= 4'd8)
    else $error("encoded_length out of range");

  // a one-byte word is a small literal and never overlong
  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && encoded_length == 4'd1 |-> !overlong && decoded_value < 32'd185)
    else $error("bad single-byte word");

  // overlong words carry at least five value bytes plus the header
  a_overlong_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && overlong |-> encoded_length >= 4'd6)
    else $error("overlong word too short");

  // a word needs a byte in flight: none right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("word shown right after reset");

endmodule

bind varint_lite_stream_decoder_core vlsd_checker u_vlsd_checker (.*);

`default_nettype wire

// ----- tb/tb_varint_lite_stream_decoder_core.sv -----
// Testbench for varint_lite_stream_decoder_core: byte stream in, checked decoded words out.
`timescale 1ns / 1ps

module tb_varint_lite_stream_decoder_core;
  import vlsd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] decoded_value;
  logic [3:0]  encoded_length;
  logic        overlong;
  logic        block_end;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  varint_lite_stream_decoder_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .byte_in        (byte_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .decoded_value  (decoded_value),
    .encoded_length (encoded_length),
    .overlong       (overlong),
    .block_end      (block_end),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  // Stimulus and expected words
  logic [7:0] byte_queue[$];
  result_t    words_due[$];
  int         bytes_sent = 0;
  int         bytes_taken = 0;
  logic       byte_taken = 1'b0;
  int         send_idle = 0;
  int         recv_idle = 0;

  // Shadow decode state and block counter
  dec_state_t  dec_st = '0;
  logic [15:0] block_size = 16'd0;
  logic [15:0] values_in_block = 16'd0;

  // Run statistics
  int errors = 0;
  int words_checked = 0;
  int block_ends_seen = 0;
  int overlong_seen = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 20)
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Finish a value: apply block counting and queue the word
  function void close_value(input logic [31:0] value, input logic [3:0] len,
                            input logic ovl);
    result_t     w;
    logic [15:0] next_count;
    w.value = value;
    w.length = len;
    w.overlong = ovl;
    w.block_end = 1'b0;
    next_count = values_in_block + 16'd1;
    if (block_size != 16'd0) begin
      if (next_count >= block_size || next_count == 16'd0) begin
        w.block_end = 1'b1;
        values_in_block = 16'd0;
      end else begin
        values_in_block = next_count;
      end
    end else begin
      values_in_block = 16'd0;
    end
    words_due.push_back(w);
  endfunction

  // Advance the shadow decoder by one accepted byte
  function void decode_byte(input logic [7:0] b);
    logic [2:0] announced;
    announced = 3'(b - 8'd248);
    if (dec_st.bytes_left == 3'd0) begin
      if (b < CutTwoByte) begin
        close_value({24'd0, b}, 4'd1, 1'b0);
      end else begin
        dec_st.length_so_far = 4'd1;
        dec_st.byte_position = 3'd0;
        if (b < CutMulti) begin
          dec_st.two_byte_form = 1'b1;
          dec_st.accumulator = 32'd185 + ({24'd0, 8'(b - CutTwoByte)} << 8);
          dec_st.bytes_left = 3'd1;
          dec_st.overlong_seen = 1'b0;
        end else begin
          dec_st.two_byte_form = 1'b0;
          dec_st.accumulator = 32'd0;
          dec_st.bytes_left = announced;
          dec_st.overlong_seen = (announced > 3'd4);
        end
      end
    end else begin
      dec_st.length_so_far = dec_st.length_so_far + 4'd1;
      dec_st.bytes_left = dec_st.bytes_left - 3'd1;
      if (dec_st.two_byte_form) begin
        close_value(dec_st.accumulator + {24'd0, b}, dec_st.length_so_far, 1'b0);
        dec_st.two_byte_form = 1'b0;
        dec_st.bytes_left = 3'd0;
        dec_st.accumulator = 32'd0;
      end else begin
        if (dec_st.byte_position < 3'd4)
          dec_st.accumulator = dec_st.accumulator | ({24'd0, b} << (8 * dec_st.byte_position));
        dec_st.byte_position = dec_st.byte_position + 3'd1;
        if (dec_st.bytes_left == 3'd0) begin
          close_value(dec_st.accumulator, dec_st.length_so_far, dec_st.overlong_seen);
          dec_st.accumulator = 32'd0;
          dec_st.byte_position = 3'd0;
          dec_st.overlong_seen = 1'b0;
        end
      end
    end
  endfunction

  // Driver: byte channel and output back-pressure, changed on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || byte_taken) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          byte_in <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: predict on accepted bytes, check each accepted word
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = in_valid && in_ready;
      if (byte_taken) begin
        bytes_taken++;
        decode_byte(byte_in);
      end
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          report_mismatch("word with none expected, value", decoded_value, 32'd0);
        end else begin
          want = words_due.pop_front();
          if (decoded_value !== want.value)
            report_mismatch("decoded_value", decoded_value, want.value);
          if (encoded_length !== want.length)
            report_mismatch("encoded_length", 32'(encoded_length), 32'(want.length));
          if (overlong !== want.overlong)
            report_mismatch("overlong", 32'(overlong), 32'(want.overlong));
          if (block_end !== want.block_end)
            report_mismatch("block_end", 32'(block_end), 32'(want.block_end));
          words_checked++;
          if (want.block_end) block_ends_seen++;
          if (want.overlong) overlong_seen++;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_queue.push_back(b);
    bytes_sent++;
  endtask

  // Hold off until every byte is in and every word is out, then let the pipe empty
  task automatic wait_drained();
    do @(negedge clk); while (bytes_taken != bytes_sent || words_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Register write while the decoder is idle; called on a falling edge
  task automatic set_block_size(input logic [15:0] size);
    cfg_we <= 1'b1;
    cfg_wdata <= size;
    block_size = size;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed values with random content, some loose bytes
  task automatic queue_random_stream(input int n_bytes);
    int         start;
    int         pick;
    logic [7:0] hdr;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_byte(8'($urandom_range(255)));
      end else if (pick < 40) begin
        push_byte(8'($urandom_range(184)));
      end else if (pick < 65) begin
        push_byte(8'($urandom_range(248, 185)));
        push_byte(8'($urandom_range(255)));
      end else begin
        hdr = 8'($urandom_range(255, 249));
        push_byte(hdr);
        repeat (hdr - 8'd248) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [15:0] sizes[6];
    int          idle_lo[6];
    int          idle_hi[6];
    sizes = '{16'd1, 16'd0, 16'd65535, 16'd5, 16'd2, 16'($urandom_range(40, 3))};
    idle_lo = '{6, 6, 66, 66, 0, 0};
    idle_hi = '{66, 66, 6, 6, 0, 0};

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: format boundaries, widest value, overlong headers
    set_block_size(16'd3);
    @(posedge clk);
    send_idle = 6;
    recv_idle = 66;
    push_byte(8'd0);
    push_byte(8'd184);
    push_byte(8'd185); push_byte(8'h00);
    push_byte(8'd248); push_byte(8'hff);
    push_byte(8'd249); push_byte(8'h80);
    push_byte(8'd252);
    repeat (4) push_byte(8'hff);
    push_byte(8'd253);
    push_byte(8'h01); push_byte(8'h02); push_byte(8'h03); push_byte(8'h04);
    push_byte(8'haa);
    push_byte(8'd255);
    push_byte(8'h11); push_byte(8'h22); push_byte(8'h33); push_byte(8'h44);
    push_byte(8'h55); push_byte(8'h66); push_byte(8'h77);
    wait_drained();

    // Random: block size and idling change between phases, counter carries over
    for (int p = 0; p < 6; p++) begin
      set_block_size(sizes[p]);
      @(posedge clk);
      send_idle = idle_lo[p];
      recv_idle = idle_hi[p];
      queue_random_stream(205);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    $display("Decoded %0d bytes into %0d words (%0d overlong, %0d block ends),",
             bytes_taken, words_checked, overlong_seen, block_ends_seen);
    $display("block sizes 0, 1, 2, 3, 5, %0d and 65535 under mixed stalls.", sizes[5]);
    if (errors == 0 && words_due.size() == 0) begin
      $display("tb_varint_lite_stream_decoder_core OK");
    end else begin
      $display("tb_varint_lite_stream_decoder_core NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #500us;
    $display("Timeout with %0d words still expected", words_due.size());
    $display("tb_varint_lite_stream_decoder_core NOT OK");
    $finish;
  end

endmodule
